// ===== hw/rtl/cau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared defaults, request and error codes, command and state types.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int EXP_WIDTH_DEF  = 16;

  localparam logic [3:0] REQ_ADD    = 4'd0;
  localparam logic [3:0] REQ_SUB    = 4'd1;
  localparam logic [3:0] REQ_MUL    = 4'd2;
  localparam logic [3:0] REQ_DIV    = 4'd3;
  localparam logic [3:0] REQ_NEGATE = 4'd4;
  localparam logic [3:0] REQ_MAG    = 4'd5;
  localparam logic [3:0] REQ_SQUARE = 4'd6;
  localparam logic [3:0] REQ_POWER  = 4'd7;
  localparam logic [3:0] REQ_EQUAL  = 4'd8;

  localparam logic [1:0] ERR_NONE         = 2'd0;
  localparam logic [1:0] ERR_DIV_ZERO     = 2'd1;
  localparam logic [1:0] ERR_ZERO_NEG_POW = 2'd2;

  // Operation class decided by the front end; K_NOP covers unused codes.
  typedef enum logic [3:0] {
    K_ADD, K_SUB, K_MUL, K_DIV, K_NEG, K_MAG, K_SQR, K_POW, K_EQ, K_NOP
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  div_zero;
    logic  zero_neg_pow;
    logic  exp_neg;
    logic  exp_zero;
    logic  ops_equal;
  } cmd_t;

  typedef enum logic [1:0] {JOB_CMUL, JOB_DIV, JOB_MAG} job_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PROD, ST_CMUL_END, ST_DIV_INIT, ST_DIV_RUN, ST_DIV_END,
    ST_SQRT_INIT, ST_SQRT_RUN, ST_SQRT_END, ST_PW_SKIP, ST_PW_NEXT, ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/cau_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int EXP_WIDTH  = EXP_WIDTH_DEF,
  localparam int IN_W = ((4 + 4 * DATA_WIDTH + EXP_WIDTH + 7) / 8) * 8,
  localparam int QW   = 4 * DATA_WIDTH + EXP_WIDTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [IN_W-1:0] s_tdata,
  output logic            q_valid,
  input  logic            q_pop,
  output cmd_t            q_cmd,
  output logic [QW-1:0]   q_data
);

  localparam int D  = DATA_WIDTH;
  localparam int EW = EXP_WIDTH;

  logic [3:0]    req;
  logic [D-1:0]  ar, ai, br, bi;
  logic [EW-1:0] ex;
  cmd_t          cmd;
  logic          a_zero, b_zero;

  logic [QW-1:0] fdata [2];
  cmd_t          fcmd  [2];
  logic          wp, rp;
  logic [1:0]    cnt;
  logic          push;

  assign req = s_tdata[3:0];
  assign ar  = s_tdata[4 +: D];
  assign ai  = s_tdata[4 + D +: D];
  assign br  = s_tdata[4 + 2 * D +: D];
  assign bi  = s_tdata[4 + 3 * D +: D];
  assign ex  = s_tdata[4 + 4 * D +: EW];

  assign a_zero = (ar == '0) && (ai == '0);
  assign b_zero = (br == '0) && (bi == '0);

  always_comb begin
    cmd.div_zero     = b_zero;
    cmd.zero_neg_pow = a_zero && ex[EW-1];
    cmd.exp_neg      = ex[EW-1];
    cmd.exp_zero     = (ex == '0);
    cmd.ops_equal    = (ar == br) && (ai == bi);
    case (req)
      REQ_ADD:    cmd.kind = K_ADD;
      REQ_SUB:    cmd.kind = K_SUB;
      REQ_MUL:    cmd.kind = K_MUL;
      REQ_DIV:    cmd.kind = K_DIV;
      REQ_NEGATE: cmd.kind = K_NEG;
      REQ_MAG:    cmd.kind = K_MAG;
      REQ_SQUARE: cmd.kind = K_SQR;
      REQ_POWER:  cmd.kind = K_POW;
      REQ_EQUAL:  cmd.kind = K_EQ;
      default:    cmd.kind = K_NOP;
    endcase
  end

  assign s_tready = (cnt != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (cnt != 2'd0);
  assign q_cmd    = fcmd[rp];
  assign q_data   = fdata[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      fdata[wp] <= s_tdata[4 +: QW];
      fcmd[wp]  <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop && q_valid) rp <= ~rp;
      if (push && !(q_pop && q_valid)) begin
        cnt <= cnt + 2'd1;
      end else if (!push && q_pop && q_valid) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/cau_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit back end
// Sequencer around one shared multiplier, a restoring divider and an
// integer square root, with a registered result stage.
// ----------------------------------------------------------------------------
module cau_core import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int EXP_WIDTH  = EXP_WIDTH_DEF,
  localparam int QW = 4 * DATA_WIDTH + EXP_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  cmd_t                         q_cmd,
  input  logic [QW-1:0]                q_data,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic signed [DATA_WIDTH-1:0] out_re,
  output logic signed [DATA_WIDTH-1:0] out_im,
  output logic                         out_eq,
  output logic [1:0]                   out_err,
  output logic                         out_sat
);

  localparam int D    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int EW   = EXP_WIDTH;
  localparam int NW   = 2 * D + F;      // dividend magnitude bits
  localparam int CW   = NW + 1;         // widest value that gets clamped
  localparam int RW   = 2 * D + 1;      // divider remainder
  localparam int CNTW = $clog2(NW + 1);
  localparam int BLW  = $clog2(EW + 1);

  localparam logic signed [CW-1:0] MAXV = {{(CW-D+1){1'b0}}, {(D-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = {{(CW-D+1){1'b1}}, {(D-1){1'b0}}};
  localparam bit ONE_SAT = (F >= D - 1);
  localparam logic signed [D-1:0] ONE_VAL = ONE_SAT ? {1'b0, {(D-1){1'b1}}}
                                                    : ({{(D-1){1'b0}}, 1'b1} << F);

  function automatic logic clamp_ovf(input logic signed [CW-1:0] v);
    clamp_ovf = (v > MAXV) || (v < MINV);
  endfunction

  function automatic logic signed [D-1:0] clamp_val(input logic signed [CW-1:0] v);
    if (v > MAXV) clamp_val = MAXV[D-1:0];
    else if (v < MINV) clamp_val = MINV[D-1:0];
    else clamp_val = v[D-1:0];
  endfunction

  state_t state, state_next;
  job_t   job;

  logic signed [D-1:0]   xr, xi, yr, yi, base_re, base_im;
  logic signed [2*D-1:0] p [6];
  logic [2:0]            pidx, nprod;
  logic                  pw, mb;
  logic [EW-1:0]         m;
  logic [BLW-1:0]        bl;
  logic [CNTW-1:0]       cnt;

  logic [NW-1:0]   dv, qt;
  logic [RW-1:0]   rem;
  logic [2*D-1:0]  dd;
  logic            qneg, part;

  logic [2*D-1:0]  sv;
  logic [D-1:0]    root;
  logic [D+1:0]    srem;

  logic signed [D-1:0] res_re, res_im;
  logic                res_eq, sat;
  logic [1:0]          res_err;
  logic                out_free;

  // Operand fields of the request at the queue head.
  logic signed [D-1:0] a_re, a_im, b_re, b_im;
  logic [EW-1:0]       ex, ex_mag;
  assign a_re   = q_data[0 +: D];
  assign a_im   = q_data[D +: D];
  assign b_re   = q_data[2 * D +: D];
  assign b_im   = q_data[3 * D +: D];
  assign ex     = q_data[4 * D +: EW];
  assign ex_mag = q_cmd.exp_neg ? ('0 - ex) : ex;

  // Add, subtract and negate widened by one bit, then clamped.
  logic signed [D:0]    add_re, add_im, sub_re, sub_im, neg_re, neg_im;
  assign add_re = {a_re[D-1], a_re} + {b_re[D-1], b_re};
  assign add_im = {a_im[D-1], a_im} + {b_im[D-1], b_im};
  assign sub_re = {a_re[D-1], a_re} - {b_re[D-1], b_re};
  assign sub_im = {a_im[D-1], a_im} - {b_im[D-1], b_im};
  assign neg_re = '0 - {a_re[D-1], a_re};
  assign neg_im = '0 - {a_im[D-1], a_im};

  logic signed [CW-1:0] w0_re, w0_im;
  always_comb begin
    case (q_cmd.kind)
      K_ADD: begin
        w0_re = CW'(add_re);
        w0_im = CW'(add_im);
      end
      K_SUB: begin
        w0_re = CW'(sub_re);
        w0_im = CW'(sub_im);
      end
      default: begin
        w0_re = CW'(neg_re);
        w0_im = CW'(neg_im);
      end
    endcase
  end

  // Shared multiplier.
  logic signed [D-1:0]   mul_a, mul_b;
  logic signed [2*D-1:0] prod;
  assign prod = mul_a * mul_b;

  // Complex product combine: floor shift by the fraction bits.
  logic signed [2*D:0]  cs_re, cs_im, cs_re_sh, cs_im_sh;
  logic signed [CW-1:0] cw_re, cw_im;
  assign cs_re    = {p[0][2*D-1], p[0]} - {p[1][2*D-1], p[1]};
  assign cs_im    = {p[2][2*D-1], p[2]} + {p[3][2*D-1], p[3]};
  assign cs_re_sh = cs_re >>> F;
  assign cs_im_sh = cs_im >>> F;
  assign cw_re    = CW'(cs_re_sh);
  assign cw_im    = CW'(cs_im_sh);

  // Division numerators and denominator.
  logic signed [2*D:0] nr, ni, den, nr_abs, ni_abs;
  assign nr     = {p[0][2*D-1], p[0]} + {p[1][2*D-1], p[1]};
  assign ni     = {p[3][2*D-1], p[3]} - {p[2][2*D-1], p[2]};
  assign den    = {p[4][2*D-1], p[4]} + {p[5][2*D-1], p[5]};
  assign nr_abs = nr[2*D] ? ('0 - nr) : nr;
  assign ni_abs = ni[2*D] ? ('0 - ni) : ni;

  // Restoring divider step.
  logic [RW-1:0] rt, rem_n;
  logic          dge;
  assign rt    = {rem[RW-2:0], dv[NW-1]};
  assign dge   = rt >= {1'b0, dd};
  assign rem_n = dge ? (rt - {1'b0, dd}) : rt;

  logic [CW-1:0]        q_ext;
  logic signed [CW-1:0] qs;
  assign q_ext = {1'b0, qt};
  assign qs    = qneg ? (~q_ext + 1'b1) : q_ext;

  // Square root step.
  logic [D+3:0] srt, strial;
  logic         sge;
  logic [D+3:0] sdiff;
  assign srt    = {srem, sv[2*D-1 -: 2]};
  assign strial = {2'b00, root, 2'b01};
  assign sge    = srt >= strial;
  assign sdiff  = srt - strial;

  logic signed [CW-1:0] root_w;
  assign root_w = {{(CW-D){1'b0}}, root};

  assign out_free = !m_tvalid || m_tready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.kind)
            K_MUL, K_SQR, K_MAG: state_next = ST_PROD;
            K_DIV: state_next = q_cmd.div_zero ? ST_DONE : ST_PROD;
            K_POW: begin
              if (q_cmd.zero_neg_pow || q_cmd.exp_zero) state_next = ST_DONE;
              else if (q_cmd.exp_neg) state_next = ST_PROD;
              else state_next = ST_PW_SKIP;
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_PROD: begin
        if (pidx == nprod - 3'd1) begin
          case (job)
            JOB_CMUL: state_next = ST_CMUL_END;
            JOB_DIV:  state_next = ST_DIV_INIT;
            default:  state_next = ST_SQRT_INIT;
          endcase
        end
      end
      ST_CMUL_END: begin
        if (!pw) state_next = ST_DONE;
        else if (!mb && m[EW-1]) state_next = ST_PROD;
        else state_next = ST_PW_NEXT;
      end
      ST_DIV_INIT: state_next = ST_DIV_RUN;
      ST_DIV_RUN:  if (cnt == CNTW'(1)) state_next = ST_DIV_END;
      ST_DIV_END: begin
        if (!part) state_next = ST_DIV_RUN;
        else state_next = pw ? ST_PW_SKIP : ST_DONE;
      end
      ST_SQRT_INIT: state_next = ST_SQRT_RUN;
      ST_SQRT_RUN:  if (cnt == CNTW'(1)) state_next = ST_SQRT_END;
      ST_SQRT_END:  state_next = ST_DONE;
      ST_PW_SKIP:   if (m[EW-1]) state_next = ST_PW_NEXT;
      ST_PW_NEXT:   state_next = (bl == '0) ? ST_DONE : ST_PROD;
      ST_DONE:      if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: queue pop and multiplier operand select.
  always_comb begin
    q_pop = (state == ST_IDLE) && q_valid;
    case (pidx)
      3'd0: begin mul_a = xr; mul_b = yr; end
      3'd1: begin mul_a = xi; mul_b = yi; end
      3'd2: begin mul_a = xr; mul_b = yi; end
      3'd3: begin mul_a = xi; mul_b = yr; end
      3'd4: begin mul_a = yr; mul_b = yr; end
      default: begin mul_a = yi; mul_b = yi; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        pidx    <= 3'd0;
        pw      <= 1'b0;
        mb      <= 1'b0;
        res_re  <= '0;
        res_im  <= '0;
        res_eq  <= 1'b0;
        res_err <= ERR_NONE;
        sat     <= 1'b0;
        m       <= ex_mag;
        bl      <= BLW'(EW);
        xr      <= a_re;
        xi      <= a_im;
        yr      <= b_re;
        yi      <= b_im;
        base_re <= a_re;
        base_im <= a_im;
        job     <= JOB_CMUL;
        nprod   <= 3'd4;
        case (q_cmd.kind)
          K_ADD, K_SUB, K_NEG: begin
            res_re <= clamp_val(w0_re);
            res_im <= clamp_val(w0_im);
            sat    <= clamp_ovf(w0_re) || clamp_ovf(w0_im);
          end
          K_SQR: begin
            yr <= a_re;
            yi <= a_im;
          end
          K_DIV: begin
            job     <= JOB_DIV;
            nprod   <= 3'd6;
            if (q_cmd.div_zero) res_err <= ERR_DIV_ZERO;
          end
          K_MAG: begin
            yr    <= a_re;
            yi    <= a_im;
            job   <= JOB_MAG;
            nprod <= 3'd2;
          end
          K_POW: begin
            pw <= 1'b1;
            yr <= a_re;
            yi <= a_im;
            if (q_cmd.zero_neg_pow) begin
              res_err <= ERR_ZERO_NEG_POW;
            end else if (q_cmd.exp_zero) begin
              res_re <= ONE_VAL;
              sat    <= ONE_SAT;
            end else if (q_cmd.exp_neg) begin
              // Reciprocal first: (1, 0) / a.
              xr    <= ONE_VAL;
              xi    <= '0;
              sat   <= ONE_SAT;
              job   <= JOB_DIV;
              nprod <= 3'd6;
            end
          end
          K_EQ:    res_eq <= q_cmd.ops_equal;
          default: ;
        endcase
      end
      ST_PROD: begin
        p[pidx] <= prod;
        pidx    <= (pidx == nprod - 3'd1) ? 3'd0 : pidx + 3'd1;
      end
      ST_CMUL_END: begin
        sat <= sat || clamp_ovf(cw_re) || clamp_ovf(cw_im);
        if (!pw) begin
          res_re <= clamp_val(cw_re);
          res_im <= clamp_val(cw_im);
        end else begin
          xr <= clamp_val(cw_re);
          xi <= clamp_val(cw_im);
          if (!mb && m[EW-1]) begin
            yr <= base_re;
            yi <= base_im;
            mb <= 1'b1;
          end else begin
            m  <= {m[EW-2:0], 1'b0};
            bl <= bl - 1'b1;
          end
        end
      end
      ST_DIV_INIT: begin
        dd   <= den[2*D-1:0];
        dv   <= NW'(nr_abs[2*D-1:0]) << F;
        qneg <= nr[2*D];
        rem  <= '0;
        qt   <= '0;
        cnt  <= CNTW'(NW);
        part <= 1'b0;
      end
      ST_DIV_RUN: begin
        rem <= rem_n;
        qt  <= {qt[NW-2:0], dge};
        dv  <= {dv[NW-2:0], 1'b0};
        cnt <= cnt - 1'b1;
      end
      ST_DIV_END: begin
        sat <= sat || clamp_ovf(qs);
        if (!part) begin
          res_re <= clamp_val(qs);
          dv     <= NW'(ni_abs[2*D-1:0]) << F;
          qneg   <= ni[2*D];
          rem    <= '0;
          qt     <= '0;
          cnt    <= CNTW'(NW);
          part   <= 1'b1;
        end else begin
          res_im <= clamp_val(qs);
          if (pw) begin
            base_re <= res_re;
            base_im <= clamp_val(qs);
            xr      <= res_re;
            xi      <= clamp_val(qs);
            bl      <= BLW'(EW);
          end
        end
      end
      ST_SQRT_INIT: begin
        sv   <= nr[2*D-1:0];
        root <= '0;
        srem <= '0;
        cnt  <= CNTW'(D);
      end
      ST_SQRT_RUN: begin
        srem <= sge ? sdiff[D+1:0] : srt[D+1:0];
        root <= {root[D-2:0], sge};
        sv   <= {sv[2*D-3:0], 2'b00};
        cnt  <= cnt - 1'b1;
      end
      ST_SQRT_END: begin
        res_re <= clamp_val(root_w);
        sat    <= sat || clamp_ovf(root_w);
      end
      ST_PW_SKIP: begin
        // Drop leading zeros and the top set bit of the exponent.
        m  <= {m[EW-2:0], 1'b0};
        bl <= bl - 1'b1;
      end
      ST_PW_NEXT: begin
        if (bl == '0) begin
          res_re <= xr;
          res_im <= xi;
        end else begin
          yr    <= xr;
          yi    <= xi;
          mb    <= 1'b0;
          job   <= JOB_CMUL;
          nprod <= 3'd4;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_re  <= (res_err != ERR_NONE) ? '0 : res_re;
          out_im  <= (res_err != ERR_NONE) ? '0 : res_im;
          out_eq  <= res_eq;
          out_err <= res_err;
          out_sat <= (res_err != ERR_NONE) ? 1'b0 : sat;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/complex_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Each request passes the two-entry queue and the sequenced back end, and its
// result is registered before the master side sees it. Power first skips the
// leading exponent zeros and the top set bit, then squares once per remaining
// bit and also multiplies by the base where that bit is set, after a divide for
// a negative exponent. The back end starts the next request while a finished
// result waits. Synchronous reset empties the queue and the result register.
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Signed fixed-point complex ALU: add, subtract, multiply, divide, negate,
// magnitude, square, integer power and equality, with saturation and error
// codes. A front end classifies requests into a short queue; a sequenced
// back end evaluates them and holds the finished result for the master side.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int EXP_WIDTH  = EXP_WIDTH_DEF,
  localparam int IN_W  = ((4 + 4 * DATA_WIDTH + EXP_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((2 * DATA_WIDTH + 4 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // s_tdata, from bit 0: req_type, a_re, a_im, b_re, b_im, exponent, zero fill
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // m_tdata, from bit 0: res_re, res_im, is_equal, error_code, saturated,
  // zero fill
  output logic [OUT_W-1:0] m_tdata
);

  localparam int QW = 4 * DATA_WIDTH + EXP_WIDTH;

  logic                         q_valid, q_pop;
  cmd_t                         q_cmd;
  logic [QW-1:0]                q_data;
  logic signed [DATA_WIDTH-1:0] res_re, res_im;
  logic                         is_equal, saturated;
  logic [1:0]                   error_code;

  // The front end takes a transfer whenever its queue has room, so requests
  // keep flowing in while the back end is busy or a result is waiting.
  cau_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .EXP_WIDTH  (EXP_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd),
    .q_data   (q_data)
  );

  // The back end runs one request at a time and parks the answer in its
  // output register, starting the next request while that result waits.
  cau_core #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .EXP_WIDTH  (EXP_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd),
    .q_data   (q_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .out_re   (res_re),
    .out_im   (res_im),
    .out_eq   (is_equal),
    .out_err  (error_code),
    .out_sat  (saturated)
  );

  assign m_tdata = OUT_W'({saturated, error_code, is_equal, res_im, res_re});

endmodule

// ===== verif/complex_arithmetic_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Directed and random requests go through the slave side of the unit. Each
// accepted transfer is run through a wide-integer model of the fixed-point
// arithmetic, and every result transfer is compared field by field with the
// oldest prediction. Both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_test;
  import cau_pkg::*;

  localparam int DW     = DATA_WIDTH_DEF;
  localparam int FB     = FRAC_BITS_DEF;
  localparam int EW     = EXP_WIDTH_DEF;
  localparam int IN_W   = ((4 + 4 * DW + EW + 7) / 8) * 8;
  localparam int OUT_W  = ((2 * DW + 4 + 7) / 8) * 8;
  localparam int N_RAND = 800;
  localparam int STALL_LIMIT = 20000;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [DW-1:0] re;
    logic [DW-1:0] im;
    logic          eq;
    logic [1:0]    err;
    logic          sat;
  } cau_result_t;

  // Holds predicted results in issue order and checks the unit against them.
  class result_board;
    cau_result_t pending[$];
    int          errors;

    function wide_t clamp_word(wide_t v, inout bit sat);
      wide_t hi;
      wide_t lo;
      hi = (wide_t'(1) <<< (DW - 1)) - 1;
      lo = -(wide_t'(1) <<< (DW - 1));
      if (v > hi) begin
        sat = 1;
        return hi;
      end
      if (v < lo) begin
        sat = 1;
        return lo;
      end
      return v;
    endfunction

    // Products are floored by the arithmetic shift.
    function void cplx_mul(wide_t xr, wide_t xi, wide_t yr, wide_t yi,
                           output wide_t rr, output wide_t ri, inout bit sat);
      rr = clamp_word((xr * yr - xi * yi) >>> FB, sat);
      ri = clamp_word((xr * yi + xi * yr) >>> FB, sat);
    endfunction

    // Quotients truncate toward zero, as signed division does.
    function void cplx_div(wide_t xr, wide_t xi, wide_t yr, wide_t yi,
                           output wide_t rr, output wide_t ri, inout bit sat);
      wide_t d;
      d  = yr * yr + yi * yi;
      rr = clamp_word(((xr * yr + xi * yi) <<< FB) / d, sat);
      ri = clamp_word(((xi * yr - xr * yi) <<< FB) / d, sat);
    endfunction

    function wide_t floor_sqrt(wide_t n);
      wide_t root;
      wide_t t;
      root = 0;
      for (int k = 126; k >= 0; k -= 2) begin
        t = root + (wide_t'(1) <<< k);
        if (n >= t) begin
          n    = n - t;
          root = (root >>> 1) + (wide_t'(1) <<< k);
        end else begin
          root = root >>> 1;
        end
      end
      return root;
    endfunction

    function void note_request(logic [3:0] op, logic signed [DW-1:0] ar,
                               logic signed [DW-1:0] ai, logic signed [DW-1:0] br,
                               logic signed [DW-1:0] bi, logic signed [EW-1:0] e);
      wide_t xr, xi, yr, yi, rr, ri, br_w, bi_w, one;
      bit sat;
      bit eq;
      logic [1:0] err;
      int mag;
      int top;
      cau_result_t r;
      xr = ar; xi = ai; yr = br; yi = bi;
      rr = 0; ri = 0; sat = 0; eq = 0; err = ERR_NONE;
      case (op)
        REQ_ADD: begin
          rr = clamp_word(xr + yr, sat);
          ri = clamp_word(xi + yi, sat);
        end
        REQ_SUB: begin
          rr = clamp_word(xr - yr, sat);
          ri = clamp_word(xi - yi, sat);
        end
        REQ_MUL: cplx_mul(xr, xi, yr, yi, rr, ri, sat);
        REQ_DIV: begin
          if (yr == 0 && yi == 0) err = ERR_DIV_ZERO;
          else cplx_div(xr, xi, yr, yi, rr, ri, sat);
        end
        REQ_NEGATE: begin
          rr = clamp_word(-xr, sat);
          ri = clamp_word(-xi, sat);
        end
        REQ_MAG: rr = clamp_word(floor_sqrt(xr * xr + xi * xi), sat);
        REQ_SQUARE: cplx_mul(xr, xi, xr, xi, rr, ri, sat);
        REQ_POWER: begin
          br_w = xr; bi_w = xi;
          mag  = (e < 0) ? -int'(e) : int'(e);
          if (e < 0 && xr == 0 && xi == 0) begin
            err = ERR_ZERO_NEG_POW;
          end else begin
            if (e < 0) begin
              one = clamp_word(wide_t'(1) <<< FB, sat);
              cplx_div(one, 0, xr, xi, br_w, bi_w, sat);
            end
            if (mag == 0) begin
              rr = clamp_word(wide_t'(1) <<< FB, sat);
            end else begin
              top = 31;
              while (!mag[top]) top--;
              rr = br_w; ri = bi_w;
              for (int i = top - 1; i >= 0; i--) begin
                cplx_mul(rr, ri, rr, ri, rr, ri, sat);
                if (mag[i]) cplx_mul(rr, ri, br_w, bi_w, rr, ri, sat);
              end
            end
          end
        end
        REQ_EQUAL: eq = (ar == br) && (ai == bi);
        default: ;
      endcase
      if (err != ERR_NONE) begin
        rr = 0; ri = 0; sat = 0;
      end
      r.re = rr[DW-1:0]; r.im = ri[DW-1:0];
      r.eq = eq; r.err = err; r.sat = sat;
      pending.push_back(r);
    endfunction

    function void check_result(logic [OUT_W-1:0] d);
      cau_result_t x;
      cau_result_t got;
      got.re  = d[DW-1:0];
      got.im  = d[2*DW-1:DW];
      got.eq  = d[2*DW];
      got.err = d[2*DW+2:2*DW+1];
      got.sat = d[2*DW+3];
      if (pending.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, actual %h", $time, d);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (got.re !== x.re) begin
        $display("%0t: res_re expected %h actual %h", $time, x.re, got.re);
        errors++;
      end
      if (got.im !== x.im) begin
        $display("%0t: res_im expected %h actual %h", $time, x.im, got.im);
        errors++;
      end
      if (got.eq !== x.eq) begin
        $display("%0t: is_equal expected %b actual %b", $time, x.eq, got.eq);
        errors++;
      end
      if (got.err !== x.err) begin
        $display("%0t: error_code expected %0d actual %0d", $time, x.err, got.err);
        errors++;
      end
      if (got.sat !== x.sat) begin
        $display("%0t: saturated expected %b actual %b", $time, x.sat, got.sat);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;

  result_board board;
  int          idle_cycles;
  bit          calm_phase;
  int          stall_left;

  complex_arithmetic_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Mostly short gaps, now and then a long one, none at all in calm phases.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm_phase || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Operand mix: full-range words, small values near unity, zero and extremes.
  function automatic logic [DW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: return $urandom_range(0, 2 ** 19) - 2 ** 18;
      8: return '0;
      default: begin
        case ($urandom_range(0, 3))
          0: return {1'b1, {(DW - 1){1'b0}}};
          1: return {1'b0, {(DW - 1){1'b1}}};
          2: return 32'sd1 <<< FB;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // One slave-side transfer; valid stays high across back-to-back items.
  task automatic send_request(logic [3:0] op, logic [DW-1:0] ar, logic [DW-1:0] ai,
                              logic [DW-1:0] br, logic [DW-1:0] bi,
                              logic [EW-1:0] e);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W - 4 - 4 * DW - EW){1'b0}}, e, bi, br, ai, ar, op};
    do @(posedge clk); while (!s_tready);
    board.note_request(op, ar, ai, br, bi, e);
  endtask

  // Result side: check on every transfer, then stall at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_result(m_tdata);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready   <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 99) < 30) begin
        stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                 : $urandom_range(10, 50);
        m_tready   <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any transfer on either side ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  localparam logic [DW-1:0] W_MIN = {1'b1, {(DW - 1){1'b0}}};
  localparam logic [DW-1:0] W_MAX = {1'b0, {(DW - 1){1'b1}}};
  localparam logic [DW-1:0] W_ONE = 1 << FB;

  initial begin
    logic [3:0]    op;
    logic [DW-1:0] ar, ai;
    logic [EW-1:0] e;
    board       = new();
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    calm_phase  = 1'b0;
    stall_left  = 0;
    idle_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every operation, errors, zero exponent, unused codes.
    send_request(REQ_ADD,    W_MAX, W_MIN, W_MAX, W_MIN, '0);
    send_request(REQ_SUB,    W_MIN, W_MAX, W_MAX, W_MIN, '0);
    send_request(REQ_MUL,    W_MIN, W_MIN, W_MIN, W_MIN, '0);
    send_request(REQ_MUL,    W_ONE, -W_ONE, 32'h0001_8000, 32'h0000_4000, '0);
    send_request(REQ_DIV,    W_ONE, W_ONE, '0, '0, '0);
    send_request(REQ_DIV,    W_MAX, W_MIN, 32'd1, '0, '0);
    send_request(REQ_DIV,    32'h0003_0000, -32'sd7, 32'h0002_0000, 32'hFFFF_0000, '0);
    send_request(REQ_NEGATE, W_MIN, W_MAX, '0, '0, '0);
    send_request(REQ_MAG,    W_MIN, W_MIN, '0, '0, '0);
    send_request(REQ_MAG,    32'h0003_0000, 32'h0004_0000, '0, '0, '0);
    send_request(REQ_SQUARE, W_MAX, 32'h0000_8000, '0, '0, '0);
    send_request(REQ_POWER,  '0, '0, '0, '0, '0);
    send_request(REQ_POWER,  '0, '0, '0, '0, '1);
    send_request(REQ_POWER,  32'h0000_8000, 32'h0000_8000, '0, '0, 16'sh8000);
    send_request(REQ_POWER,  32'h0001_0100, 32'hFFFF_FF00, '0, '0, 16'sh7FFF);
    send_request(REQ_POWER,  32'h0001_8000, '0, '0, '0, -16'sd3);
    send_request(REQ_POWER,  32'h0000_0001, 32'h0000_0001, '0, '0, -16'sd1);
    send_request(REQ_EQUAL,  W_MIN, W_MAX, W_MIN, W_MAX, '0);
    send_request(REQ_EQUAL,  W_MIN, W_MAX, W_MIN, W_MIN, '0);
    for (int c = 9; c < 16; c++) send_request(4'(c), W_MAX, W_MIN, W_MAX, '1, '1);

    // Random part, with calm stretches where neither side idles.
    for (int n = 0; n < N_RAND; n++) begin
      if (n % 100 == 0) calm_phase = ($urandom_range(0, 3) == 0);
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                        : 4'($urandom_range(0, 8));
      ar = pick_word();
      ai = pick_word();
      e  = ($urandom_range(0, 4) == 0) ? EW'($urandom) : EW'($urandom_range(0, 16) - 8);
      if (op == REQ_EQUAL && $urandom_range(0, 1)) begin
        send_request(op, ar, ai, ar, ai, e);
      end else begin
        send_request(op, ar, ai, pick_word(), pick_word(), e);
      end
    end
    s_tvalid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/cau_pkg.sv
hw/rtl/cau_front.sv
hw/rtl/cau_core.sv
hw/rtl/complex_arithmetic_unit.sv
verif/complex_arithmetic_unit_test.sv
